### rtl/mrt_pkg.sv
// Shared types and constants for the mapping region table.
// Status codes, the stored region record and the sequencer states.
// No dependencies.
package mrt_pkg;

  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned FILES_DEF     = 16;
  localparam int unsigned PAGE_BITS_DEF = 12;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 31;
  localparam int unsigned DESC_W = 4;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned CNT_W  = 5;
  // wide enough to compare a descriptor against any FILES value below 512
  localparam int unsigned FCMP_W = 9;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_DESC   = 3'd1,
    ST_OVERLAP    = 3'd2,
    ST_FULL       = 3'd3,
    ST_MISALIGNED = 3'd4,
    ST_NOT_FOUND  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  // one stored region
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
    logic              anon;
    logic              shared;
    logic [DESC_W-1:0] desc;
  } region_t;

  localparam int unsigned REGION_W = $bits(region_t);

endpackage

### rtl/mapping_region_table_unit.sv
// Mapping region table: map and unmap requests against a table of regions.
// Depends on mrt_pkg and mrt_ram.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------
//   request | in        | in_valid_i/in_stall_o| operation, region_addr/len, anonymous,
//           |           |                      | shared, file_desc, desc_open
//   result  | out       | out_valid_o/         | status, result_addr, slot_index,
//           |           | out_stall_i          | freed_len/desc/file_backed, active_count
//
// A map request that fails its descriptor check, or an unmap request that fails
// its alignment check, goes from idle straight to the finish state. Any other
// request walks the region RAM one slot a cycle through its single read port;
// an unmap hit or a map overlap ends the walk early.
// Reset clears the valid bits and the count at once; the RAM needs no clearing.
// One request is in service at a time. A finished result sits in the output
// register while the next request is taken; a stalled result only holds up
// the commit of the request after it.
module mapping_region_table_unit
  import mrt_pkg::*;
#(
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned FILES     = FILES_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [ADDR_W-1:0] region_addr_i,
  input  logic [LEN_W-1:0]  region_len_i,
  input  logic              anonymous_i,
  input  logic              shared_i,
  input  logic [DESC_W-1:0] file_desc_i,
  input  logic              desc_open_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [STAT_W-1:0] status_o,
  output logic [ADDR_W-1:0] result_addr_o,
  output logic [SLOT_W-1:0] slot_index_o,
  output logic [LEN_W-1:0]  freed_len_o,
  output logic [DESC_W-1:0] freed_desc_o,
  output logic              freed_file_backed_o,
  output logic [CNT_W-1:0]  active_count_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // sequencer
  state_e state_q, state_d;

  // captured request
  logic              req_op_q;
  logic [ADDR_W-1:0] req_addr_q;
  logic [LEN_W-1:0]  req_len_q;
  logic              req_anon_q;
  logic              req_shared_q;
  logic [DESC_W-1:0] req_desc_q;

  // walk over the slots: issue counter and the slot whose data is due now
  logic [IW:0]   cnt_q, cnt_d;
  logic          chk_v_q, chk_v_d;
  logic [IW-1:0] chk_idx_q, chk_idx_d;

  // result of the walk
  status_e       res_status_q, res_status_d;
  logic [IW-1:0] res_slot_q, res_slot_d;
  logic          free_found_q, free_found_d;
  logic [LEN_W-1:0]  res_len_q, res_len_d;
  logic [DESC_W-1:0] res_desc_q, res_desc_d;
  logic              res_fb_q, res_fb_d;

  // table state outside the RAM
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [CW-1:0]    count_q, count_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [DESC_W-1:0] out_desc_q;
  logic              out_fb_q;
  logic [CNT_W-1:0]  out_count_q;

  // RAM ports
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_raddr;
  region_t       ram_wdata, ram_rdata;
  logic [REGION_W-1:0] ram_rdata_raw;

  logic in_xfer, issuing, commit, last_chk, slot_hit_v;
  logic bad_desc, misaligned, ok_commit;
  logic [ADDR_W-1:0] new_end, old_end;
  logic overlap;
  logic [IW+SLOT_W-1:0] slot_wide;
  logic [CW+CNT_W-1:0]  count_wide;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign bad_desc   = !anonymous_i &&
                      ((FCMP_W'(file_desc_i) >= FCMP_W'(FILES)) || !desc_open_i);
  assign misaligned = (region_addr_i[PAGE_BITS-1:0] != '0);

  assign issuing   = (state_q == S_SCAN) && (cnt_q < (IW+1)'(SLOTS));
  assign ram_re    = issuing;
  assign ram_raddr = cnt_q[IW-1:0];
  assign last_chk  = (chk_idx_q == IW'(SLOTS - 1));

  assign ram_rdata  = region_t'(ram_rdata_raw);
  assign slot_hit_v = valid_q[chk_idx_q];

  // both ends wrap modulo 2^32
  assign new_end = req_addr_q + ADDR_W'(req_len_q);
  assign old_end = ram_rdata.start + ADDR_W'(ram_rdata.length);
  assign overlap = !((new_end <= ram_rdata.start) || (req_addr_q >= old_end));

  // commit only once the output register can take the result
  assign commit    = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign ok_commit = commit && (res_status_q == ST_OK);
  assign ram_we    = ok_commit && !req_op_q;

  always_comb begin
    ram_wdata        = '0;
    ram_wdata.start  = req_addr_q;
    ram_wdata.length = req_len_q;
    ram_wdata.anon   = req_anon_q;
    ram_wdata.shared = req_shared_q;
    ram_wdata.desc   = req_anon_q ? '0 : req_desc_q;
  end

  mrt_ram #(
    .WIDTH(REGION_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(res_slot_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    chk_v_d      = 1'b0;
    chk_idx_d    = chk_idx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    free_found_d = free_found_q;
    res_len_d    = res_len_q;
    res_desc_d   = res_desc_q;
    res_fb_d     = res_fb_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cnt_d        = '0;
          free_found_d = 1'b0;
          res_slot_d   = '0;
          res_len_d    = '0;
          res_desc_d   = '0;
          res_fb_d     = 1'b0;
          if (!operation_i && bad_desc) begin
            res_status_d = ST_BAD_DESC;
            state_d      = S_FIN;
          end else if (operation_i && misaligned) begin
            res_status_d = ST_MISALIGNED;
            state_d      = S_FIN;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue the next read, check the slot whose data has arrived
        if (issuing) begin
          cnt_d     = cnt_q + 1'b1;
          chk_v_d   = 1'b1;
          chk_idx_d = cnt_q[IW-1:0];
        end
        if (chk_v_q) begin
          if (!req_op_q) begin
            if (slot_hit_v && overlap) begin
              res_status_d = ST_OVERLAP;
              state_d      = S_FIN;
            end else begin
              if (!slot_hit_v && !free_found_q) begin
                free_found_d = 1'b1;
                res_slot_d   = chk_idx_q;
              end
              if (last_chk) begin
                res_status_d = (free_found_q || !slot_hit_v) ? ST_OK : ST_FULL;
                state_d      = S_FIN;
              end
            end
          end else begin
            if (slot_hit_v && (ram_rdata.start == req_addr_q)) begin
              res_status_d = ST_OK;
              res_slot_d   = chk_idx_q;
              res_len_d    = ram_rdata.length;
              res_desc_d   = ram_rdata.anon ? '0 : ram_rdata.desc;
              res_fb_d     = !ram_rdata.anon;
              state_d      = S_FIN;
            end else if (last_chk) begin
              res_status_d = ST_NOT_FOUND;
              state_d      = S_FIN;
            end
          end
          // drop the read still in flight when the walk ends early
          if (state_d == S_FIN) begin
            chk_v_d = 1'b0;
          end
        end
      end
      S_FIN: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // table update on a successful commit
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    if (ok_commit) begin
      if (!req_op_q) begin
        valid_d[res_slot_q] = 1'b1;
        count_d             = count_q + 1'b1;
      end else begin
        valid_d[res_slot_q] = 1'b0;
        if (count_q != '0) begin
          count_d = count_q - 1'b1;
        end
      end
    end
  end

  assign slot_wide  = {{SLOT_W{1'b0}}, res_slot_q};
  assign count_wide = {{CNT_W{1'b0}}, count_d};

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      chk_v_q      <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      chk_v_q      <= chk_v_d;
      free_found_q <= free_found_d;
      valid_q      <= valid_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      res_status_q <= res_status_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    res_slot_q <= res_slot_d;
    res_len_q  <= res_len_d;
    res_desc_q <= res_desc_d;
    res_fb_q   <= res_fb_d;
    if (in_xfer) begin
      req_op_q     <= operation_i;
      req_addr_q   <= region_addr_i;
      req_len_q    <= region_len_i;
      req_anon_q   <= anonymous_i;
      req_shared_q <= shared_i;
      req_desc_q   <= file_desc_i;
    end
    if (commit) begin
      out_status_q <= res_status_q;
      out_addr_q   <= (res_status_q == ST_OK) ? req_addr_q : '0;
      out_slot_q   <= (res_status_q == ST_OK) ? slot_wide[SLOT_W-1:0] : '0;
      out_len_q    <= res_len_q;
      out_desc_q   <= res_desc_q;
      out_fb_q     <= res_fb_q;
      out_count_q  <= count_wide[CNT_W-1:0];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign result_addr_o       = out_addr_q;
  assign slot_index_o        = out_slot_q;
  assign freed_len_o         = out_len_q;
  assign freed_desc_o        = out_desc_q;
  assign freed_file_backed_o = out_fb_q;
  assign active_count_o      = out_count_q;

endmodule

### rtl/mrt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module mrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mrt_checker.sv
// Port-level checks for the mapping region table, bound to the top level.
// Depends on mrt_pkg and mapping_region_table_unit.
module mrt_checker
  import mrt_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [STAT_W-1:0] status_o,
  input logic [ADDR_W-1:0] result_addr_o,
  input logic [SLOT_W-1:0] slot_index_o,
  input logic [LEN_W-1:0]  freed_len_o,
  input logic              freed_file_backed_o,
  input logic [CNT_W-1:0]  active_count_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(result_addr_o) && $stable(active_count_o))
    else $error("result changed while stalled");

  // one request in service: a transfer in makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in service");

  // failed requests report nothing besides the status and count
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
    (result_addr_o == '0) && (slot_index_o == '0) && (freed_len_o == '0) &&
    !freed_file_backed_o)
    else $error("failed request carries data");

  // count stays within the table
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (SLOTS > 31) || (32'(active_count_o) <= SLOTS))
    else $error("active count above table size");

  // after a transfer, a changed count comes only with a successful status
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i ##1 out_valid_o && $changed(active_count_o) |->
    (status_o == ST_OK))
    else $error("count changed on a failed request");

endmodule

bind mapping_region_table_unit mrt_checker #(.SLOTS(SLOTS)) u_mrt_checker (.*);
